FILE: hw/rtl/pfe_pkg.sv
// Shared types and constants for the postfix expression evaluator.
// Used by the divider, the controller, the datapath and the top level; depends on nothing.
package pfe_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned ValueW  = 31;
  localparam int unsigned OpW     = 3;
  localparam int unsigned ActionW = 2;
  localparam int unsigned StatusW = 3;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 40;

  typedef enum logic [ActionW-1:0] {
    ACT_NUM = 2'd0,
    ACT_OP  = 2'd1,
    ACT_END = 2'd2
  } action_e;

  typedef enum logic [OpW-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ERR_NONE      = 3'd0,
    ERR_UNDERFLOW = 3'd1,
    ERR_DIVZERO   = 3'd2,
    ERR_BADOP     = 3'd3,
    ERR_LEFTOVER  = 3'd4,
    ERR_OVERFLOW  = 3'd5
  } err_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DIV,
    ST_END
  } state_e;

  typedef struct packed {
    logic push;
    logic rd_a;
    logic alu_wr;
    logic div_start;
    logic div_wr;
    logic pop2;
    logic set_err;
    err_e err_code;
    logic emit;
  } pfe_cmd_t;

  typedef struct packed {
    logic full;
    logic lt2;
    logic err_set;
    logic tos_zero;
    logic div_done;
    logic out_free;
    op_e  op;
  } pfe_stat_t;

endpackage

FILE: hw/rtl/pfe_div.sv
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating.
// Depends on pfe_pkg for the word width.
module pfe_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [pfe_pkg::WordW-1:0] a_i,
  input  logic [pfe_pkg::WordW-1:0] b_i,
  output logic                      done_o,
  output logic [pfe_pkg::WordW-1:0] quot_o
);

  localparam int unsigned W  = pfe_pkg::WordW;
  localparam int unsigned CW = $clog2(W);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  mb_q, mb_d;
  logic          neg_q, neg_d;
  logic [W:0]    shifted;
  logic [W:0]    trial;

  assign shifted = {rem_q, quo_q[W-1]};
  assign trial   = shifted - {1'b0, mb_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    mb_d   = mb_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = a_i[W-1] ? (W'(0) - a_i) : a_i;
      mb_d   = b_i[W-1] ? (W'(0) - b_i) : b_i;
      neg_d  = a_i[W-1] ^ b_i[W-1];
    end else if (busy_q) begin
      // restore when the trial subtraction goes negative
      if (trial[W]) begin
        rem_d = shifted[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b0};
      end else begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    mb_q  <= mb_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? (W'(0) - quo_q) : quo_q;

endmodule

FILE: hw/rtl/pfe_datapath.sv
// Operand stack (memory plus top-of-stack register), ALU, divider and result register.
// Depends on pfe_pkg and pfe_div; driven by pfe_ctrl commands.
module pfe_datapath #(
  parameter int unsigned STACK_DEPTH = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pfe_pkg::pfe_cmd_t            cmd_i,
  output pfe_pkg::pfe_stat_t           stat_o,
  input  logic [pfe_pkg::ValueW-1:0]   value_i,
  input  logic [pfe_pkg::OpW-1:0]      op_code_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [pfe_pkg::WordW-1:0]    result_value_o,
  output logic [pfe_pkg::StatusW-1:0]  status_o
);

  localparam int unsigned W  = pfe_pkg::WordW;
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  logic [W-1:0]       mem [STACK_DEPTH];
  logic [W-1:0]       rdata_q;
  logic [W-1:0]       tos_q, tos_d;
  logic [CW-1:0]      count_q, count_d;
  pfe_pkg::err_e      err_q, err_d;
  pfe_pkg::op_e       op_q;
  logic               out_valid_q, out_valid_d;
  logic [W-1:0]       res_q;
  pfe_pkg::err_e      status_q;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      rd_addr;
  logic [W-1:0]       alu_res;
  logic               div_done;
  logic [W-1:0]       div_quot;

  assign wr_addr = AW'(count_q - CW'(1));
  assign rd_addr = AW'(count_q - CW'(2));

  // tos_q holds the top entry; the memory holds the entries below it
  always_ff @(posedge clk_i) begin
    if (cmd_i.push && (count_q != '0)) begin
      mem[wr_addr] <= tos_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_a) begin
      rdata_q <= mem[rd_addr];
      op_q    <= pfe_pkg::op_e'(op_code_i);
    end
  end

  always_comb begin
    case (op_q)
      pfe_pkg::OP_ADD: alu_res = rdata_q + tos_q;
      pfe_pkg::OP_SUB: alu_res = rdata_q - tos_q;
      pfe_pkg::OP_MUL: alu_res = rdata_q * tos_q;
      default:         alu_res = '0;
    endcase
  end

  pfe_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .a_i     (rdata_q),
    .b_i     (tos_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_comb begin
    tos_d       = tos_q;
    count_d     = count_q;
    err_d       = err_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.push) begin
      tos_d   = {1'b0, value_i};
      count_d = count_q + CW'(1);
    end
    if (cmd_i.alu_wr) begin
      tos_d   = alu_res;
      count_d = count_q - CW'(1);
    end
    if (cmd_i.div_wr) begin
      tos_d   = div_quot;
      count_d = count_q - CW'(1);
    end
    if (cmd_i.pop2) begin
      count_d = count_q - CW'(2);
    end
    if (cmd_i.set_err) begin
      err_d = cmd_i.err_code;
    end
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      count_d     = '0;
      err_d       = pfe_pkg::ERR_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      err_q       <= pfe_pkg::ERR_NONE;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tos_q <= tos_d;
    if (cmd_i.emit) begin
      if (err_q != pfe_pkg::ERR_NONE) begin
        res_q    <= '0;
        status_q <= err_q;
      end else if (count_q == CW'(1)) begin
        res_q    <= tos_q;
        status_q <= pfe_pkg::ERR_NONE;
      end else begin
        res_q    <= '0;
        status_q <= pfe_pkg::ERR_LEFTOVER;
      end
    end
  end

  assign stat_o.full     = (count_q >= CW'(STACK_DEPTH));
  assign stat_o.lt2      = (count_q < CW'(2));
  assign stat_o.err_set  = (err_q != pfe_pkg::ERR_NONE);
  assign stat_o.tos_zero = (tos_q == '0);
  assign stat_o.div_done = div_done;
  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign stat_o.op       = op_q;

  assign out_valid_o    = out_valid_q;
  assign result_value_o = res_q;
  assign status_o       = status_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(STACK_DEPTH))
    else $error("stack count above depth");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> (count_q < CW'(STACK_DEPTH)) && (err_q == pfe_pkg::ERR_NONE))
    else $error("push into full stack or after error");

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> (count_q == '0) && (err_q == pfe_pkg::ERR_NONE) && out_valid_q)
    else $error("end of expression did not clear state");

  a_div_wr_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_wr |-> div_done && (count_q >= CW'(2)))
    else $error("quotient written without divider completion");

endmodule

FILE: hw/rtl/pfe_ctrl.sv
// Token sequencer: decodes each transfer and steps the datapath through it.
// Depends on pfe_pkg; talks to pfe_datapath by command and status structs only.
module pfe_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [pfe_pkg::ActionW-1:0]  action_i,
  input  pfe_pkg::pfe_stat_t           stat_i,
  output pfe_pkg::pfe_cmd_t            cmd_o
);

  pfe_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pfe_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.err_code = pfe_pkg::ERR_NONE;
    case (state_q)
      pfe_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (pfe_pkg::action_e'(action_i))
            pfe_pkg::ACT_NUM: begin
              if (!stat_i.err_set) begin
                if (stat_i.full) begin
                  cmd_o.set_err  = 1'b1;
                  cmd_o.err_code = pfe_pkg::ERR_OVERFLOW;
                end else begin
                  cmd_o.push = 1'b1;
                end
              end
            end
            pfe_pkg::ACT_OP: begin
              if (!stat_i.err_set) begin
                if (stat_i.lt2) begin
                  cmd_o.set_err  = 1'b1;
                  cmd_o.err_code = pfe_pkg::ERR_UNDERFLOW;
                end else begin
                  cmd_o.rd_a = 1'b1;
                  state_d    = pfe_pkg::ST_FETCH;
                end
              end
            end
            pfe_pkg::ACT_END: state_d = pfe_pkg::ST_END;
            default: ;
          endcase
        end
      end
      pfe_pkg::ST_FETCH: begin
        // lower (left) operand is now in the read register
        case (stat_i.op)
          pfe_pkg::OP_ADD, pfe_pkg::OP_SUB, pfe_pkg::OP_MUL: begin
            cmd_o.alu_wr = 1'b1;
            state_d      = pfe_pkg::ST_IDLE;
          end
          pfe_pkg::OP_DIV: begin
            if (stat_i.tos_zero) begin
              cmd_o.pop2     = 1'b1;
              cmd_o.set_err  = 1'b1;
              cmd_o.err_code = pfe_pkg::ERR_DIVZERO;
              state_d        = pfe_pkg::ST_IDLE;
            end else begin
              cmd_o.div_start = 1'b1;
              state_d         = pfe_pkg::ST_DIV;
            end
          end
          default: begin
            cmd_o.pop2     = 1'b1;
            cmd_o.set_err  = 1'b1;
            cmd_o.err_code = pfe_pkg::ERR_BADOP;
            state_d        = pfe_pkg::ST_IDLE;
          end
        endcase
      end
      pfe_pkg::ST_DIV: begin
        if (stat_i.div_done) begin
          cmd_o.div_wr = 1'b1;
          state_d      = pfe_pkg::ST_IDLE;
        end
      end
      pfe_pkg::ST_END: begin
        // hold until the result register is free
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = pfe_pkg::ST_IDLE;
        end
      end
      default: state_d = pfe_pkg::ST_IDLE;
    endcase
  end

endmodule

FILE: hw/rtl/postfix_expression_evaluator_core.sv
// Postfix (RPN) expression evaluator. Tokens arrive one per transfer: the kind
// in s_axis_tuser, value and operator in s_axis_tdata. A number token is pushed
// on its transfer; add, subtract and multiply go through a registered stack read
// of the lower operand, then the ALU; divide goes through the stack read, divider
// start, the bit-serial divider and quotient write-back. No new token is taken
// until an operator is done. An end token is taken by the transfer, then emits
// result and status on the master side; it waits only while an earlier result
// is still untaken. Other tokens are taken while a result waits. No clearing
// pass after reset is needed.
module postfix_expression_evaluator_core #(
  parameter int unsigned STACK_DEPTH = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [30:0] value, [33:31] op_code, [39:34] zero
  input  logic [pfe_pkg::InDataW-1:0]   s_axis_tdata,
  // [1:0] action
  input  logic [pfe_pkg::ActionW-1:0]   s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [31:0] result_value, [34:32] status, [39:35] zero
  output logic [pfe_pkg::OutDataW-1:0]  m_axis_tdata
);

  localparam int unsigned W = pfe_pkg::WordW;
  localparam int unsigned V = pfe_pkg::ValueW;
  localparam int unsigned O = pfe_pkg::OpW;
  localparam int unsigned S = pfe_pkg::StatusW;

  pfe_pkg::pfe_cmd_t  cmd;
  pfe_pkg::pfe_stat_t stat;
  logic [W-1:0]       result_value;
  logic [S-1:0]       status;

  pfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .action_i   (s_axis_tuser),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pfe_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .value_i        (s_axis_tdata[V-1:0]),
    .op_code_i      (s_axis_tdata[V+O-1:V]),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .result_value_o (result_value),
    .status_o       (status)
  );

  assign m_axis_tdata = {(pfe_pkg::OutDataW - W - S)'(0), status, result_value};

endmodule
